// ===== hdl/wrrs_pkg.sv =====
`default_nettype none
package wrrs_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int WEIGHT_W        = 16;
    localparam int RND_W           = 31;
    localparam int TOTAL_W         = 20;
    localparam int STATUS_W        = 2;
    localparam int INDEX_W         = 4;
    localparam int ALU_W           = TOTAL_W + 1;
    localparam int STEP_W          = $clog2(RND_W);

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 2'd0,
        ST_FULL     = 2'd1,
        ST_SELECTED = 2'd2,
        ST_DEFAULT  = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_ADD   = 3'd1,
        S_DIV   = 3'd2,
        S_WALK  = 3'd3,
        S_DEC_W = 3'd4,
        S_DEC_T = 3'd5
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/wrrs_alu.sv =====
`default_nettype none
module wrrs_alu (
    input  wire logic [wrrs_pkg::ALU_W-1:0] i_a,
    input  wire logic [wrrs_pkg::ALU_W-1:0] i_b,
    input  wire wrrs_pkg::t_alu_op          i_op,
    output logic      [wrrs_pkg::ALU_W-1:0] o_y,
    output logic                            o_borrow
);

    logic [wrrs_pkg::ALU_W:0] full;

    always_comb begin
        unique case (i_op)
            wrrs_pkg::ALU_ADD: full = {1'b0, i_a} + {1'b0, i_b};
            wrrs_pkg::ALU_SUB: full = {1'b0, i_a} - {1'b0, i_b};
            default:           full = '0;
        endcase
    end

    assign o_y      = full[wrrs_pkg::ALU_W-1:0];
    assign o_borrow = (i_op == wrrs_pkg::ALU_SUB) && full[wrrs_pkg::ALU_W];

endmodule
`default_nettype wire

// ===== hdl/wrrs_mem.sv =====
`default_nettype none
module wrrs_mem #(
    parameter int DEPTH = wrrs_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [wrrs_pkg::WEIGHT_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [wrrs_pkg::WEIGHT_W-1:0] o_rdata
);

    logic [wrrs_pkg::WEIGHT_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/weighted_random_reply_select.sv =====
`default_nettype none
// Channel    Handshake                Payload
// command    start / busy             i_op, i_weight, i_random_value
// result     o_result_valid strobe    o_status, o_index
// config     i_cfg_we                 i_cfg_wdata (reduce_mode)
//
// Append: the result strobe follows the S_ADD state; from idle when full.
// Select: restoring modulo of i_random_value by the total in S_DIV, then
// one entry per cycle walked through the weight memory in S_WALK, plus
// S_DEC_W and S_DEC_T when a weight is lowered. A zero total answers from idle.
// Synchronous active-low reset clears count, total and mode; no clearing pass.
// The receiver cannot stall; each result shows for one cycle only.
module weighted_random_reply_select #(
    parameter int MAX_ENTRIES = wrrs_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_op,
    input  wire logic [wrrs_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic [wrrs_pkg::RND_W-1:0]    i_random_value,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    output logic                               o_result_valid,
    output logic      [wrrs_pkg::STATUS_W-1:0] o_status,
    output logic      [wrrs_pkg::INDEX_W-1:0]  o_index
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int TW    = wrrs_pkg::TOTAL_W;
    localparam int AW    = wrrs_pkg::ALU_W;
    localparam int OW    = wrrs_pkg::INDEX_W;

    wrrs_pkg::t_state  r_state, n_state;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TW-1:0]     r_total, n_total;
    logic              r_reduce_mode, n_reduce_mode;

    wrrs_pkg::t_status              r_status, n_status;
    logic [OW-1:0]                  r_index, n_index;
    logic [wrrs_pkg::WEIGHT_W-1:0]  r_weight, n_weight;
    logic [wrrs_pkg::RND_W-1:0]     r_rnd, n_rnd;
    logic [TW-1:0]                  r_rem, n_rem;
    logic [wrrs_pkg::STEP_W-1:0]    r_step, n_step;
    logic [IDX_W-1:0]               r_idx, n_idx;

    logic [AW-1:0]          alu_a, alu_b, alu_y;
    wrrs_pkg::t_alu_op      alu_op;
    logic                   alu_borrow;

    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr, mem_raddr;
    logic [wrrs_pkg::WEIGHT_W-1:0]  mem_wdata, mem_rdata;

    logic [AW-1:0]          rem_sh;
    logic [CNT_W-1:0]       idx_inc;
    logic                   walk_last;
    logic [IDX_W+OW-1:0]    idx_ext;
    logic [IDX_W+OW-1:0]    cnt_ext;

    wrrs_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_op     (alu_op),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    wrrs_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rem_sh    = {r_rem, r_rnd[wrrs_pkg::RND_W-1]};
    assign idx_inc   = CNT_W'(r_idx) + CNT_W'(1);
    assign walk_last = (idx_inc == r_count);
    assign idx_ext   = {{OW{1'b0}}, r_idx};
    assign cnt_ext   = {{OW{1'b0}}, r_count[IDX_W-1:0]};

    // shared unit operand select
    always_comb begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = wrrs_pkg::ALU_SUB;
        unique case (r_state)
            wrrs_pkg::S_ADD: begin
                alu_a  = AW'(r_total);
                alu_b  = AW'(r_weight);
                alu_op = wrrs_pkg::ALU_ADD;
            end
            wrrs_pkg::S_DIV: begin
                alu_a = rem_sh;
                alu_b = AW'(r_total);
            end
            wrrs_pkg::S_WALK: begin
                alu_a = AW'(r_rem);
                alu_b = AW'(mem_rdata);
            end
            wrrs_pkg::S_DEC_W: begin
                alu_a = AW'(r_weight);
                alu_b = AW'(1);
            end
            wrrs_pkg::S_DEC_T: begin
                alu_a = AW'(r_total);
                alu_b = AW'(1);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        n_count       = r_count;
        n_total       = r_total;
        n_reduce_mode = i_cfg_we ? i_cfg_wdata : r_reduce_mode;
        n_status      = r_status;
        n_index       = r_index;
        n_weight      = r_weight;
        n_rnd         = r_rnd;
        n_rem         = r_rem;
        n_step        = r_step;
        n_idx         = r_idx;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdata     = alu_y[wrrs_pkg::WEIGHT_W-1:0];
        mem_raddr     = '0;
        unique case (r_state)
            wrrs_pkg::S_IDLE: begin
                if (start) begin
                    if (!i_op) begin
                        if (r_count == CNT_W'(MAX_ENTRIES)) begin
                            n_done   = 1'b1;
                            n_status = wrrs_pkg::ST_FULL;
                            n_index  = '0;
                        end else begin
                            n_weight = i_weight;
                            n_state  = wrrs_pkg::S_ADD;
                        end
                    end else if (r_total == '0) begin
                        n_done   = 1'b1;
                        n_status = wrrs_pkg::ST_DEFAULT;
                        n_index  = '0;
                    end else begin
                        n_rnd   = i_random_value;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = wrrs_pkg::S_DIV;
                    end
                end
            end
            wrrs_pkg::S_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = r_count[IDX_W-1:0];
                mem_wdata = r_weight;
                n_total   = alu_y[TW-1:0];
                n_count   = r_count + CNT_W'(1);
                n_done    = 1'b1;
                n_status  = wrrs_pkg::ST_ADDED;
                n_index   = cnt_ext[OW-1:0];
                n_state   = wrrs_pkg::S_IDLE;
            end
            wrrs_pkg::S_DIV: begin
                n_rem  = alu_borrow ? rem_sh[TW-1:0] : alu_y[TW-1:0];
                n_rnd  = {r_rnd[wrrs_pkg::RND_W-2:0], 1'b0};
                n_step = r_step + wrrs_pkg::STEP_W'(1);
                if (r_step == wrrs_pkg::STEP_W'(wrrs_pkg::RND_W - 1)) begin
                    n_idx   = '0;
                    n_state = wrrs_pkg::S_WALK;
                end
            end
            wrrs_pkg::S_WALK: begin
                if (alu_borrow) begin
                    n_weight = mem_rdata;
                    if (r_reduce_mode && (mem_rdata > wrrs_pkg::WEIGHT_W'(1))) begin
                        n_state = wrrs_pkg::S_DEC_W;
                    end else begin
                        n_done   = 1'b1;
                        n_status = wrrs_pkg::ST_SELECTED;
                        n_index  = idx_ext[OW-1:0];
                        n_state  = wrrs_pkg::S_IDLE;
                    end
                end else begin
                    n_rem = alu_y[TW-1:0];
                    if (walk_last) begin
                        n_done   = 1'b1;
                        n_status = wrrs_pkg::ST_DEFAULT;
                        n_index  = '0;
                        n_state  = wrrs_pkg::S_IDLE;
                    end else begin
                        n_idx     = idx_inc[IDX_W-1:0];
                        mem_raddr = idx_inc[IDX_W-1:0];
                    end
                end
            end
            wrrs_pkg::S_DEC_W: begin
                mem_we  = 1'b1;
                n_state = wrrs_pkg::S_DEC_T;
            end
            wrrs_pkg::S_DEC_T: begin
                n_total  = alu_y[TW-1:0];
                n_done   = 1'b1;
                n_status = wrrs_pkg::ST_SELECTED;
                n_index  = idx_ext[OW-1:0];
                n_state  = wrrs_pkg::S_IDLE;
            end
            default: begin
                n_state = wrrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= wrrs_pkg::S_IDLE;
            r_done        <= 1'b0;
            r_count       <= '0;
            r_total       <= '0;
            r_reduce_mode <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_done        <= n_done;
            r_count       <= n_count;
            r_total       <= n_total;
            r_reduce_mode <= n_reduce_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_index  <= n_index;
        r_weight <= n_weight;
        r_rnd    <= n_rnd;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_idx    <= n_idx;
    end

    assign busy           = (r_state != wrrs_pkg::S_IDLE);
    assign o_result_valid = r_done;
    assign o_status       = r_status;
    assign o_index        = r_index;

endmodule
`default_nettype wire
